>>> hw/rtl/frma_pkg.sv
// Shared types and constants of the moving-average frame rate meter.
package frma_pkg;

    localparam int TICK_W       = 32;
    localparam int LEN_W        = 7;
    localparam int STAMP_W      = 64;
    localparam int RATE_W       = 32;
    localparam int FRAC_W       = 8;
    localparam int NUM_W        = LEN_W + TICK_W + FRAC_W;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;
    localparam int DEF_MAX_WIN  = 64;

    localparam logic [TICK_W-1:0] TICK_RATE_RST  = TICK_W'(1000);
    localparam logic [LEN_W-1:0]  WINDOW_LEN_RST = LEN_W'(16);

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic rd;
        logic upd;
    } t_ring_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> hw/rtl/frma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/frma_ring.sv
// Interval ring with running window sum; fill count marks entries written since clear.
module frma_ring import frma_pkg::*; #(
    parameter int MAX_WINDOW = DEF_MAX_WIN,
    parameter int SUM_W      = TICK_W + $clog2(MAX_WINDOW)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ring_ctl         i_ctl,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [TICK_W-1:0] i_diff,
    output logic [SUM_W-1:0]  o_sum
);

    localparam int PTR_W = $clog2(MAX_WINDOW);

    logic [PTR_W-1:0]  r_ptr;
    logic [PTR_W:0]    r_fill;
    logic [SUM_W-1:0]  r_sum;
    logic [PTR_W-1:0]  w_ptr_eff;
    logic [TICK_W-1:0] w_rdata;
    logic [TICK_W-1:0] w_old;

    assign w_ptr_eff = (32'(r_ptr) >= 32'(i_len)) ? '0 : r_ptr;
    assign w_old     = (32'(w_ptr_eff) < 32'(r_fill)) ? w_rdata : '0;

    frma_ram #(
        .WIDTH (TICK_W),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.upd),
        .i_waddr (w_ptr_eff),
        .i_wdata (i_diff),
        .i_re    (i_ctl.rd),
        .i_raddr (w_ptr_eff),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_ptr  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_ctl.upd) begin
            r_sum <= r_sum - SUM_W'(w_old) + SUM_W'(i_diff);
            if (32'(w_ptr_eff) == 32'(r_fill)) begin
                r_fill <= r_fill + 1'b1;
            end
            if (32'(w_ptr_eff) + 32'd1 >= 32'(i_len)) begin
                r_ptr <= '0;
            end else begin
                r_ptr <= w_ptr_eff + 1'b1;
            end
        end
    end

    assign o_sum = r_sum;

endmodule

>>> hw/rtl/frma_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, saturated result.
module frma_div import frma_pkg::*; #(
    parameter int SUM_W = TICK_W + 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [SUM_W-1:0]  i_den,
    output t_div_stat         o_stat,
    output logic [RATE_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_den;
    logic [NUM_W-1:0] r_sh;
    logic             r_zero;
    logic [SUM_W:0]   w_rem_sh;
    logic [SUM_W:0]   w_diff;
    logic             w_ge;

    assign w_rem_sh = {r_rem, r_sh[NUM_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh   <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SUM_W-1:0] : w_rem_sh[SUM_W-1:0];
            r_sh  <= {r_sh[NUM_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot = r_zero ? '0 :
                    (|r_sh[NUM_W-1:RATE_W]) ? '1 : r_sh[RATE_W-1:0];

endmodule

>>> hw/rtl/frame_rate_moving_average.sv
// Moving-average frame rate meter: timestamp deltas in, Q24.8 frames per second out.
//
// One request per frame event carries a 64-bit tick timestamp; each request yields one
// result. A measured request passes these steps from acceptance to a valid result:
// form the interval and read the ring, update the window sum, load the divider, run
// the bit-serial restoring divider one quotient bit at a time and, once the output
// register is free, present the result. The first request after reset goes straight
// to presenting its result and a request with an unchanged timestamp skips from the
// ring read to presenting, both with rate 0 and measured low. One request is in work
// at a time; the output register lets a new request be accepted while a result waits.
// No clearing pass is needed after reset or after a window length write.
module frame_rate_moving_average import frma_pkg::*; #(
    parameter int MAX_WINDOW = DEF_MAX_WIN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [STAMP_W-1:0]    s_axis_tdata,   // [63:0] timestamp
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [RATE_W-1:0]     m_axis_tdata,   // [31:0] frame_rate
    output logic [0:0]            m_axis_tuser,   // [0] measured
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W = TICK_W + $clog2(MAX_WINDOW);

    t_state             r_state;
    t_state             n_state;
    logic [TICK_W-1:0]  r_tick;
    logic [LEN_W-1:0]   r_wlen;
    logic [STAMP_W-1:0] r_last;
    logic               r_seen;
    logic [TICK_W-1:0]  r_diff;
    logic               r_skip;
    logic               r_meas;
    logic [NUM_W-1:0]   r_num;
    logic               r_ovalid;
    logic [RATE_W-1:0]  r_orate;
    logic               r_omeas;

    logic [LEN_W-1:0]         w_len;
    logic [STAMP_W-1:0]       w_diff64;
    logic [LEN_W+TICK_W-1:0]  w_prod;
    logic [SUM_W-1:0]         w_sum;
    logic [RATE_W-1:0]        w_quot;
    t_ring_ctl                w_ring;
    t_div_stat                w_div;
    logic                     w_accept;
    logic                     w_first;
    logic                     w_load_num;
    logic                     w_div_start;
    logic                     w_out_load;

    always_comb begin
        if (r_wlen == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_wlen) > 32'(MAX_WINDOW)) begin
            w_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_len = r_wlen;
        end
    end

    assign w_diff64 = s_axis_tdata - r_last;
    assign w_prod   = (LEN_W+TICK_W)'(w_len) * (LEN_W+TICK_W)'(r_tick);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_first  = !r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_ring.clear  = i_cfg_we && (i_cfg_index == CFG_WINDOW_LEN);
        w_ring.rd     = 1'b0;
        w_ring.upd    = 1'b0;
        w_load_num    = 1'b0;
        w_div_start   = 1'b0;
        w_out_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (w_first) begin
                        n_state = S_DONE;
                    end else begin
                        w_ring.rd = 1'b1;
                        n_state   = S_READ;
                    end
                end
            end
            S_READ: begin
                if (r_skip) begin
                    n_state = S_DONE;
                end else begin
                    w_ring.upd = 1'b1;
                    w_load_num = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= TICK_RATE_RST;
            r_wlen   <= WINDOW_LEN_RST;
            r_last   <= '0;
            r_seen   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_TICK_RATE) begin
                r_tick <= i_cfg_data[TICK_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == CFG_WINDOW_LEN) begin
                r_wlen <= i_cfg_data[LEN_W-1:0];
            end
            if (w_accept) begin
                r_last <= s_axis_tdata;
                r_seen <= 1'b1;
            end
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_diff <= (|w_diff64[STAMP_W-1:TICK_W]) ? '1 : w_diff64[TICK_W-1:0];
            r_skip <= (w_diff64 == '0);
            r_meas <= 1'b0;
        end
        if (w_load_num) begin
            r_num  <= {w_prod, FRAC_W'(0)};
            r_meas <= 1'b1;
        end
        if (w_out_load) begin
            r_orate <= r_meas ? w_quot : '0;
            r_omeas <= r_meas;
        end
    end

    frma_ring #(
        .MAX_WINDOW (MAX_WINDOW),
        .SUM_W      (SUM_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ring),
        .i_len   (w_len),
        .i_diff  (r_diff),
        .o_sum   (w_sum)
    );

    frma_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (w_sum),
        .o_stat  (w_div),
        .o_quot  (w_quot)
    );

    assign m_axis_tvalid   = r_ovalid;
    assign m_axis_tdata    = r_orate;
    assign m_axis_tuser[0] = r_omeas;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.busy |-> r_state == S_DIV)
        else $error("divider running outside the divide state");

    a_unmeasured_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tdata == '0)
        else $error("unmeasured result carries a nonzero rate");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("second request accepted while one is in work");

endmodule

>>> bench/tb.sv
// Testbench for frame_rate_moving_average: directed table plus random phases.
`timescale 1ns / 1ps

module tb import frma_pkg::*; ();

    localparam int MAX_WIN         = DEF_MAX_WIN;
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 600;
    localparam int DRAIN_CYCLES    = 60;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int EXP_DEPTH       = 64;
    localparam int DIR_DEPTH       = 32;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic              measured;
    } t_rate_result;

    typedef enum logic {ROW_STAMP, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [STAMP_W-1:0]    value;
        bit                    fixed;
        t_rate_result          want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [STAMP_W-1:0]    s_axis_tdata = '0;      // [63:0] timestamp
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [RATE_W-1:0]     m_axis_tdata;           // [31:0] frame_rate
    logic [0:0]            m_axis_tuser;           // [0] measured
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // typed expectation riding along with the request
    bit                    req_fixed = 1'b0;
    t_rate_result          req_want = '0;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;

    t_rate_result exp_buf[EXP_DEPTH];
    int unsigned  exp_wr = 0;
    int unsigned  exp_rd = 0;
    t_dir_row     dir_tab[DIR_DEPTH];
    int           n_dir = 0;
    int           mismatches = 0;
    int           stall_cycles = 0;

    // predictor state
    logic [TICK_W-1:0]  pr_tick;
    logic [LEN_W-1:0]   pr_win;
    logic [STAMP_W-1:0] pr_last;
    bit                 pr_seen;
    logic [31:0]        pr_ring[MAX_WIN];
    int unsigned        pr_ptr;
    logic [63:0]        pr_sum;

    frame_rate_moving_average u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic void clear_window();
        foreach (pr_ring[k]) pr_ring[k] = '0;
        pr_ptr = 0;
        pr_sum = '0;
    endfunction

    function automatic t_rate_result predict_rate(input logic [STAMP_W-1:0] stamp);
        logic [63:0] gap64;
        logic [31:0] gap;
        int unsigned len;
        logic [63:0] num;
        logic [63:0] quo;
        t_rate_result res;
        res = '0;
        if (!pr_seen) begin
            pr_seen = 1'b1;
            pr_last = stamp;
            return res;
        end
        gap64 = stamp - pr_last;
        pr_last = stamp;
        if (gap64 == 64'd0)
            return res;
        gap = (gap64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap64[31:0];
        len = (pr_win == '0) ? 1 : (int'(pr_win) > MAX_WIN) ? MAX_WIN : int'(pr_win);
        if (pr_ptr >= len)
            pr_ptr = 0;
        pr_sum = pr_sum - 64'(pr_ring[pr_ptr]) + 64'(gap);
        pr_ring[pr_ptr] = gap;
        pr_ptr = (pr_ptr + 1 >= len) ? 0 : pr_ptr + 1;
        num = 64'(len) * 64'(pr_tick) * 64'd256;
        quo = (pr_sum != 64'd0) ? num / pr_sum : 64'd0;
        res.rate = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
        res.measured = 1'b1;
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    endtask

    // predictor, scoreboard
    always @(posedge i_clk) begin
        t_rate_result want;
        t_rate_result pred;
        if (!i_rst_n) begin
            pr_tick = TICK_RATE_RST;
            pr_win  = WINDOW_LEN_RST;
            pr_last = '0;
            pr_seen = 1'b0;
            clear_window();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TICK_RATE) begin
                    pr_tick = i_cfg_data[TICK_W-1:0];
                end else if (i_cfg_index == CFG_WINDOW_LEN) begin
                    pr_win = i_cfg_data[LEN_W-1:0];
                    clear_window();
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred = predict_rate(s_axis_tdata);
                exp_buf[exp_wr % EXP_DEPTH] = req_fixed ? req_want : pred;
                exp_wr++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (exp_wr == exp_rd) begin
                    note_mismatch("result with no request pending", '0, 64'(m_axis_tdata));
                end else begin
                    want = exp_buf[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (want.rate !== m_axis_tdata)
                        note_mismatch("frame_rate", 64'(want.rate), 64'(m_axis_tdata));
                    if (want.measured !== m_axis_tuser[0])
                        note_mismatch("measured", 64'(want.measured), 64'(m_axis_tuser[0]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("frame_rate_moving_average regression: fail");
            $finish;
        end else if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                     || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random stalls and one long hold-off
    initial begin : rx_side
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_stamp(input logic [STAMP_W-1:0] stamp, input bit fixed,
                              input t_rate_result want);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        req_fixed     <= fixed;
        req_want      <= want;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_row(input t_dir_row r);
        dir_tab[n_dir] = r;
        n_dir++;
    endfunction

    function automatic t_dir_row stamp_row(input logic [63:0] stamp, input bit fixed,
                                           input logic [31:0] rate, input logic meas);
        t_dir_row r;
        r.kind  = ROW_STAMP;
        r.idx   = CFG_TICK_RATE;
        r.value = stamp;
        r.fixed = fixed;
        r.want  = '{rate, meas};
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [31:0] value);
        t_dir_row r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.value = 64'(value);
        r.fixed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic logic [STAMP_W-1:0] next_stamp(input logic [STAMP_W-1:0] cur,
                                                      input logic [63:0] period);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return cur;
        else if (pick < 10)
            return {$urandom, $urandom};
        else if (pick < 15)
            return cur + {24'd0, 8'($urandom_range(1, 255)), 32'($urandom)};
        else if (pick < 20)
            return cur + 64'h0000_0000_FFFF_FFF0 + 64'($urandom_range(0, 31));
        else if (pick < 30)
            return cur + 64'($urandom_range(1, 16));
        return cur + period + 64'($urandom_range(0, 32'(period >> 3)));
    endfunction

    initial begin : stimulus
        logic [STAMP_W-1:0] cur;
        logic [63:0]        period;
        logic [31:0]        tick;
        logic [31:0]        win;

        add_row(stamp_row(64'd5, 1'b1, 32'd0, 1'b0));     // first event
        add_row(stamp_row(64'd5, 1'b1, 32'd0, 1'b0));     // unchanged stamp
        add_row(stamp_row(64'd1005, 1'b1, 32'd4096, 1'b1));
        add_row(stamp_row(64'h0000_0100_0000_03ED, 1'b0, '0, 1'b0));
        add_row(stamp_row(64'hFFFF_FFFF_FFFF_FFF0, 1'b0, '0, 1'b0));
        add_row(stamp_row(64'h10, 1'b0, '0, 1'b0));       // counter wrap
        add_row(stamp_row(64'h11, 1'b0, '0, 1'b0));
        add_row(cfg_row(CFG_TICK_RATE, 32'd0));
        add_row(stamp_row(64'h20, 1'b1, 32'd0, 1'b1));    // zero tick rate
        add_row(cfg_row(CFG_TICK_RATE, 32'hFFFF_FFFF));
        add_row(cfg_row(CFG_WINDOW_LEN, 32'd64));
        add_row(stamp_row(64'h21, 1'b1, 32'hFFFF_FFFF, 1'b1)); // rate overflow
        add_row(stamp_row(64'h21, 1'b1, 32'd0, 1'b0));
        add_row(cfg_row(CFG_WINDOW_LEN, 32'd0));
        add_row(stamp_row(64'h1021, 1'b0, '0, 1'b0));
        add_row(stamp_row(64'h2021, 1'b0, '0, 1'b0));
        add_row(cfg_row(CFG_WINDOW_LEN, 32'd127));
        add_row(cfg_row(CFG_TICK_RATE, 32'd1));
        add_row(stamp_row(64'h3021, 1'b0, '0, 1'b0));
        add_row(stamp_row(64'h1_0000_3020, 1'b0, '0, 1'b0)); // just below saturation
        add_row(stamp_row(64'h2_0000_3020, 1'b0, '0, 1'b0)); // just above
        add_row(cfg_row(CFG_WINDOW_LEN, 32'd1));
        add_row(cfg_row(CFG_TICK_RATE, 32'd1000));
        add_row(stamp_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0, 1'b0));
        add_row(stamp_row(64'h0, 1'b0, '0, 1'b0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < n_dir; k++) begin
            if (dir_tab[k].kind == ROW_CFG) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                cfg_write(dir_tab[k].idx, dir_tab[k].value[31:0]);
            end else begin
                send_stamp(dir_tab[k].value, dir_tab[k].fixed, dir_tab[k].want);
            end
        end

        cur = 64'h0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            s_axis_tvalid <= 1'b0;
            wait_drained();
            case (p)
                0: begin tick = 32'd1_000_000;  win = 32'd8;   end
                1: begin tick = 32'hFFFF_FFFF;  win = 32'd64;  end
                2: begin tick = 32'd1;          win = 32'd1;   end
                3: begin tick = 32'd0;          win = 32'd2;   end
                4: begin tick = $urandom;       win = 32'd0;   end
                5: begin tick = 32'd90_000;     win = 32'd65;  end
                6: begin tick = $urandom;       win = $urandom_range(0, 127); end
                default: begin tick = 32'd1000; win = $urandom_range(1, 64); end
            endcase
            cfg_write(CFG_TICK_RATE, tick);
            cfg_write(CFG_WINDOW_LEN, win);
            if (p == NUM_PHASES - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            if (p == 1)
                hold_req = 1'b1;
            period = 64'd1 << $urandom_range(0, 30);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                cur = next_stamp(cur, period);
                send_stamp(cur, 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();

        if (mismatches == 0 && exp_wr == exp_rd) begin
            $display("frame_rate_moving_average regression: pass");
        end else begin
            $display("frame_rate_moving_average regression: fail");
        end
        $finish;
    end

endmodule
